@@ design/dca_pkg.sv @@
// Package for the decimal complex accumulator.
// Holds the transaction structs, op codes and command kinds shared by the modules; every module imports it.
// No dependencies.
package dca_pkg;

    // Width and count of the packed BCD fields
    localparam int NIB_W        = 4;
    localparam int FIELD_DIGITS = 4;
    localparam int MAG_W        = NIB_W * FIELD_DIGITS;

    // Command queue between front and back
    localparam int Q_DEPTH = 2;
    localparam int Q_AW    = $clog2(Q_DEPTH);

    // Input op codes
    localparam logic [1:0] OP_LOAD = 2'd0;
    localparam logic [1:0] OP_ADD  = 2'd1;
    localparam logic [1:0] OP_SUB  = 2'd2;

    // Input transaction
    typedef struct packed {
        logic [1:0]       op;
        logic             real_neg;
        logic [MAG_W-1:0] real_mag;
        logic             imag_neg;
        logic [MAG_W-1:0] imag_mag;
    } t_in;

    // Result transaction
    typedef struct packed {
        logic             res_real_neg;
        logic [MAG_W-1:0] res_real_mag;
        logic             res_imag_neg;
        logic [MAG_W-1:0] res_imag_mag;
        logic             bad_digit;
    } t_out;

    // One signed-magnitude part
    typedef struct packed {
        logic             neg;
        logic [MAG_W-1:0] mag;
    } t_part;

    // Classified command kinds
    typedef enum logic [1:0] {
        CMD_LOAD,
        CMD_ADD,
        CMD_BAD,
        CMD_HOLD
    } t_kind;

    // Command passed through the queue
    typedef struct packed {
        t_kind kind;
        t_part re;
        t_part im;
    } t_cmd;

endpackage

@@ design/decimal_complex_accumulator_top.sv @@
// Decimal complex accumulator. Each accepted transaction loads, adds to or
// subtracts from a complex accumulator held as sign plus packed BCD magnitude
// per part, and returns the updated accumulator as one result. One transaction
// is taken per clock while the queue is not full; the front classifies
// combinationally into a two-entry queue at the accepting edge, and the
// accumulator update loads the result register when the back pops the command.
// The input stalls only when the queue is full, which happens when the output
// is stalled. The sustained rate is set by the accumulator loop, closed through
// a ripple BCD add over the working digits. Magnitudes wrap modulo ten to the
// power of min(DIGITS, 4); a digit above nine in any nibble of a load, add or
// subtract flags bad_digit and leaves the accumulator as it was, as does op 3.
// Depends on dca_pkg, dca_front, dca_queue and dca_back.
module decimal_complex_accumulator_top #(
    parameter int DIGITS = 4
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_in_valid,
    output logic           o_in_stall,
    input  dca_pkg::t_in   i_in_data,
    output logic           o_out_valid,
    input  logic           i_out_stall,
    output dca_pkg::t_out  o_out_data
);
    import dca_pkg::*;

    localparam int WORK_DIGITS = (DIGITS < FIELD_DIGITS) ? DIGITS : FIELD_DIGITS;

    t_cmd front_cmd;
    t_cmd queue_cmd;
    logic q_full;
    logic q_empty;
    logic q_pop;
    logic q_push;

    assign o_in_stall = q_full;
    assign q_push     = i_in_valid && !q_full;

    dca_front #(
        .WORK_DIGITS (WORK_DIGITS)
    ) u_front (
        .i_in  (i_in_data),
        .o_cmd (front_cmd)
    );

    dca_queue u_queue (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_push     (q_push),
        .i_push_cmd (front_cmd),
        .o_full     (q_full),
        .i_pop      (q_pop),
        .o_pop_cmd  (queue_cmd),
        .o_empty    (q_empty)
    );

    dca_back #(
        .WORK_DIGITS (WORK_DIGITS)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (queue_cmd),
        .i_empty     (q_empty),
        .o_pop       (q_pop),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_data  (o_out_data)
    );

endmodule

@@ design/dca_front.sv @@
// Front end of the decimal complex accumulator: checks digits and classifies ops.
// Subtract is folded into add by flipping the operand sign.
// Depends on dca_pkg.
module dca_front #(
    parameter int WORK_DIGITS = 4
) (
    input  dca_pkg::t_in  i_in,
    output dca_pkg::t_cmd o_cmd
);
    import dca_pkg::*;

    logic             bad;
    logic [MAG_W-1:0] mask;

    // Any nibble above nine in either field is a bad digit
    always_comb begin
        bad = 1'b0;
        for (int k = 0; k < FIELD_DIGITS; k++) begin
            if (i_in.real_mag[NIB_W*k +: NIB_W] > 4'd9) bad = 1'b1;
            if (i_in.imag_mag[NIB_W*k +: NIB_W] > 4'd9) bad = 1'b1;
        end
    end

    // Keep only the working digits
    always_comb begin
        mask = '0;
        for (int k = 0; k < FIELD_DIGITS; k++) begin
            if (k < WORK_DIGITS) mask[NIB_W*k +: NIB_W] = '1;
        end
    end

    // Classify the transaction
    always_comb begin
        o_cmd.re.mag = i_in.real_mag & mask;
        o_cmd.im.mag = i_in.imag_mag & mask;
        o_cmd.re.neg = i_in.real_neg;
        o_cmd.im.neg = i_in.imag_neg;
        unique case (i_in.op)
            OP_LOAD: o_cmd.kind = bad ? CMD_BAD : CMD_LOAD;
            OP_ADD:  o_cmd.kind = bad ? CMD_BAD : CMD_ADD;
            OP_SUB: begin
                o_cmd.kind   = bad ? CMD_BAD : CMD_ADD;
                o_cmd.re.neg = ~i_in.real_neg;
                o_cmd.im.neg = ~i_in.imag_neg;
            end
            default: o_cmd.kind = CMD_HOLD;
        endcase
    end

endmodule

@@ design/dca_queue.sv @@
// Short command queue between the front and back of the accumulator.
// Register-based FIFO of Q_DEPTH entries.
// Depends on dca_pkg.
module dca_queue (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  dca_pkg::t_cmd i_push_cmd,
    output logic          o_full,
    input  logic          i_pop,
    output dca_pkg::t_cmd o_pop_cmd,
    output logic          o_empty
);
    import dca_pkg::*;

    t_cmd            r_mem [Q_DEPTH];
    logic [Q_AW-1:0] r_wr_ptr, n_wr_ptr;
    logic [Q_AW-1:0] r_rd_ptr, n_rd_ptr;
    logic [Q_AW:0]   r_count, n_count;

    assign o_full    = (r_count == Q_AW'(0) + (Q_AW+1)'(Q_DEPTH));
    assign o_empty   = (r_count == '0);
    assign o_pop_cmd = r_mem[r_rd_ptr];

    // Pointer and count update
    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (i_push) begin
            n_wr_ptr = (r_wr_ptr == Q_AW'(Q_DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
        end
        if (i_pop) begin
            n_rd_ptr = (r_rd_ptr == Q_AW'(Q_DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
        end
        case ({i_push, i_pop})
            2'b10:   n_count = r_count + 1'b1;
            2'b01:   n_count = r_count - 1'b1;
            default: n_count = r_count;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    // Storage
    always_ff @(posedge i_clk) begin
        if (i_push) r_mem[r_wr_ptr] <= i_push_cmd;
    end

endmodule

@@ design/dca_back.sv @@
// Back end of the decimal complex accumulator: BCD sign-magnitude arithmetic,
// accumulator registers and the registered result stage.
// Depends on dca_pkg.
module dca_back #(
    parameter int WORK_DIGITS = 4
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  dca_pkg::t_cmd i_cmd,
    input  logic          i_empty,
    output logic          o_pop,
    output logic          o_out_valid,
    input  logic          i_out_stall,
    output dca_pkg::t_out o_out_data
);
    import dca_pkg::*;

    t_part r_acc_re, n_acc_re;
    t_part r_acc_im, n_acc_im;
    logic  r_out_valid;
    t_out  r_out_data;

    // BCD add over the working digits; returns {carry, sum}
    function automatic logic [MAG_W:0] bcd_add(logic [MAG_W-1:0] x, logic [MAG_W-1:0] y,
                                               logic cin);
        logic             c;
        logic [4:0]       d;
        logic [MAG_W-1:0] s;
        c = cin;
        s = '0;
        for (int k = 0; k < FIELD_DIGITS; k++) begin
            if (k < WORK_DIGITS) begin
                d = {1'b0, x[NIB_W*k +: NIB_W]} + {1'b0, y[NIB_W*k +: NIB_W]} + {4'b0, c};
                if (d > 5'd9) begin
                    d = d + 5'd6;
                    c = 1'b1;
                end else begin
                    c = 1'b0;
                end
                s[NIB_W*k +: NIB_W] = d[3:0];
            end
        end
        return {c, s};
    endfunction

    // Nines' complement of the working digits
    function automatic logic [MAG_W-1:0] nines(logic [MAG_W-1:0] x);
        logic [MAG_W-1:0] r;
        r = '0;
        for (int k = 0; k < FIELD_DIGITS; k++) begin
            if (k < WORK_DIGITS) r[NIB_W*k +: NIB_W] = 4'd9 - x[NIB_W*k +: NIB_W];
        end
        return r;
    endfunction

    // Signed-magnitude add; sum wraps modulo ten to the working digits
    function automatic t_part part_add(t_part a, t_part b);
        logic [MAG_W:0]   sum;
        logic [MAG_W:0]   d_ab;
        logic [MAG_W:0]   d_ba;
        logic [MAG_W-1:0] m;
        logic             n;
        t_part            r;
        sum  = bcd_add(a.mag, b.mag, 1'b0);
        d_ab = bcd_add(a.mag, nines(b.mag), 1'b1);
        d_ba = bcd_add(b.mag, nines(a.mag), 1'b1);
        if (a.neg == b.neg) begin
            m = sum[MAG_W-1:0];
            n = a.neg;
        end else if (d_ab[MAG_W]) begin
            // no borrow: |a| >= |b|
            m = d_ab[MAG_W-1:0];
            n = a.neg;
        end else begin
            m = d_ba[MAG_W-1:0];
            n = b.neg;
        end
        r.mag = m;
        r.neg = n && (m != '0);
        return r;
    endfunction

    // Take a command whenever the result stage is free or draining
    assign o_pop = !i_empty && (!r_out_valid || !i_out_stall);

    // Accumulator update
    always_comb begin
        n_acc_re = r_acc_re;
        n_acc_im = r_acc_im;
        unique case (i_cmd.kind)
            CMD_LOAD: begin
                n_acc_re.mag = i_cmd.re.mag;
                n_acc_re.neg = i_cmd.re.neg && (i_cmd.re.mag != '0);
                n_acc_im.mag = i_cmd.im.mag;
                n_acc_im.neg = i_cmd.im.neg && (i_cmd.im.mag != '0);
            end
            CMD_ADD: begin
                n_acc_re = part_add(r_acc_re, i_cmd.re);
                n_acc_im = part_add(r_acc_im, i_cmd.im);
            end
            default: begin
                n_acc_re = r_acc_re;
                n_acc_im = r_acc_im;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_acc_re    <= '0;
            r_acc_im    <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (o_pop) begin
                r_acc_re    <= n_acc_re;
                r_acc_im    <= n_acc_im;
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Result register
    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_out_data.res_real_neg <= n_acc_re.neg;
            r_out_data.res_real_mag <= n_acc_re.mag;
            r_out_data.res_imag_neg <= n_acc_im.neg;
            r_out_data.res_imag_mag <= n_acc_im.mag;
            r_out_data.bad_digit    <= (i_cmd.kind == CMD_BAD);
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;

endmodule
